FILE: rtl/ksp_pkg.sv
// ----------------------------------------------------------------------------
// ksp_pkg: shared constants of the plucked string voice
// Widths, reset values and arithmetic constants used by the voice and its RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package ksp_pkg;

  localparam int MaxPeriod   = 4096;
  localparam int SampleWidth = 16;
  localparam int AddrWidth   = $clog2(MaxPeriod);
  localparam int PeriodWidth = 13;
  localparam int AmpWidth    = 16;
  localparam int GainWidth   = 16;
  localparam int SeedWidth   = 32;

  localparam logic [SeedWidth-1:0]   LcgMul    = 32'd1664525;
  localparam logic [SeedWidth-1:0]   LcgAdd    = 32'd1013904223;
  localparam logic [SeedWidth-1:0]   SeedReset = 32'd22222;
  localparam logic [GainWidth-1:0]   GainReset = 16'd65274;
  localparam logic [AmpWidth-1:0]    AmpOne    = 16'd32768;
  localparam logic [PeriodWidth-1:0] PeriodMin = 13'd2;
  localparam logic [PeriodWidth-1:0] PeriodMax = PeriodWidth'(MaxPeriod);

  // Noise: the top 23 bits of the seed, in Q0.23, times a Q1.15 amplitude.
  localparam int NoiseBits  = 23;
  localparam int NoiseShift = 38 - (SampleWidth - 1);

  // Feedback product keeps (a + b) * gain / 2^17.
  localparam int FbShift = 17;

  localparam logic [0:0] CmdPluck = 1'b0;
  localparam logic [0:0] CmdTick  = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/ksp_ram.sv
// ----------------------------------------------------------------------------
// ksp_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ksp_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/karplus_strong_pluck_voice.sv
// ----------------------------------------------------------------------------
// karplus_strong_pluck_voice: one plucked string voice
// A delay line in RAM, filled with scaled noise by a pluck and recirculated
// through a decaying two-tap average by each tick.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid_i / in_ready_o) carries one command per
// beat: cmd_i = pluck loads a new note of period_i samples at amplitude_i,
// cmd_i = tick asks for one output sample. The output channel
// (out_valid_o / out_ready_i) carries one sample_o per tick; a pluck gives
// no output beat. cfg_we_i writes cfg_wdata_i into the decay gain register.
//
// Timing. After its beat a pluck is busy for one RAM write per delay-line
// entry, paced by the single write port. A tick is busy for two RAM reads
// (current and next entry) through the one read port, then the forming of
// the sum, and then the gain multiply, the write-back and the output
// register load. The sample appears on out_valid_o as that last step ends,
// also for a tick before the first pluck, which goes straight to that step,
// and in_ready_o rises with it.
//
// Reset clears the position and the note flag, sets the noise seed to its
// reset value and puts the gain back to its default. The RAM is not cleared:
// it is only read after a pluck has written the entries in use. Ticks before
// the first pluck give zero. If the receiver stalls, the finished sample
// waits in the output register; a following tick holds in its last step
// until it is free; a pluck can still be taken and run if no tick holds.
// ----------------------------------------------------------------------------
`default_nettype none

module karplus_strong_pluck_voice (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Command channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               cmd_i,
  input  wire logic [ksp_pkg::PeriodWidth-1:0]    period_i,
  input  wire logic [ksp_pkg::AmpWidth-1:0]       amplitude_i,
  // Sample channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [ksp_pkg::SampleWidth-1:0]  sample_o,
  // Decay gain register
  input  wire logic                               cfg_we_i,
  input  wire logic [ksp_pkg::GainWidth-1:0]      cfg_wdata_i
);

  localparam int SW = ksp_pkg::SampleWidth;
  localparam int AW = ksp_pkg::AddrWidth;
  localparam int PW = ksp_pkg::PeriodWidth;
  localparam int GW = ksp_pkg::GainWidth;
  localparam int NB = ksp_pkg::NoiseBits;

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFill = 3'd1;
  localparam logic [2:0] StRdCur = 3'd2;
  localparam logic [2:0] StRdNxt = 3'd3;
  localparam logic [2:0] StSum  = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [AW-1:0]               pos_q, pos_d;
  logic [PW-1:0]               period_q, period_d;
  logic [ksp_pkg::SeedWidth-1:0] seed_q, seed_d;
  logic                        loaded_q, loaded_d;
  logic [GW-1:0]               gain_q;
  logic [AW-1:0]               cnt_q, cnt_d;
  logic [ksp_pkg::AmpWidth-1:0] amp_q, amp_d;
  logic                        zero_q, zero_d;
  logic                        out_valid_q, out_valid_d;
  logic signed [SW-1:0]        sample_q, sample_d;

  // Datapath registers, no reset needed.
  logic signed [SW-1:0]        cur_q;
  logic [SW:0]                 sum_mag_q;
  logic                        sum_neg_q;

  // RAM port signals.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [SW-1:0]               ram_wdata, ram_rdata;

  logic                        in_fire, slot_free, fill_last;
  logic [AW-1:0]               nxt_pos;
  logic [ksp_pkg::SeedWidth-1:0] seed_next;
  logic [PW-1:0]               period_clamped;
  logic [ksp_pkg::AmpWidth-1:0] amp_clamped;

  // Noise and feedback arithmetic.
  logic [NB:0]                 noise_dist;
  logic [NB+ksp_pkg::AmpWidth:0] noise_prod;
  logic [SW-1:0]               noise_mag;
  logic signed [SW:0]          tap_sum;
  logic [SW+GW:0]              fb_prod;
  logic [SW-1:0]               fb_mag;
  logic [SW-1:0]               fb_val;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  assign seed_next = ksp_pkg::SeedWidth'(seed_q * ksp_pkg::LcgMul + ksp_pkg::LcgAdd);

  // Clamp the pluck parameters as they arrive.
  always_comb begin
    period_clamped = period_i;
    if (period_i < ksp_pkg::PeriodMin) begin
      period_clamped = ksp_pkg::PeriodMin;
    end else if (period_i > ksp_pkg::PeriodMax) begin
      period_clamped = ksp_pkg::PeriodMax;
    end
    amp_clamped = (amplitude_i > ksp_pkg::AmpOne) ? ksp_pkg::AmpOne : amplitude_i;
  end

  // Circular successor of the read position.
  assign nxt_pos = (PW'({1'b0, pos_q}) + PW'(1) >= period_q) ? '0 : AW'(pos_q + AW'(1));

  assign fill_last = (PW'({1'b0, cnt_q}) == period_q - PW'(1));

  // Noise entry from the already advanced seed: -((2^23 - t) * amp >> shift).
  assign noise_dist = (NB+1)'(1 << NB) - {1'b0, seed_q[ksp_pkg::SeedWidth-1 -: NB]};
  assign noise_prod = (NB+ksp_pkg::AmpWidth+1)'(noise_dist)
                    * (NB+ksp_pkg::AmpWidth+1)'(amp_q);
  assign noise_mag  = noise_prod[ksp_pkg::NoiseShift +: SW];

  // Feedback: the sum is formed from the two taps, its magnitude registered,
  // and the gain multiply follows in the emit step.
  assign tap_sum = {cur_q[SW-1], cur_q} + {ram_rdata[SW-1], ram_rdata};
  assign fb_prod = (SW+GW+1)'(sum_mag_q) * (SW+GW+1)'(gain_q);
  assign fb_mag  = fb_prod[ksp_pkg::FbShift +: SW];
  assign fb_val  = sum_neg_q ? SW'(-fb_mag) : fb_mag;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    period_d    = period_q;
    seed_d      = seed_q;
    loaded_d    = loaded_q;
    cnt_d       = cnt_q;
    amp_d       = amp_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = fb_val;
    ram_raddr   = pos_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (cmd_i == ksp_pkg::CmdPluck) begin
            period_d = period_clamped;
            amp_d    = amp_clamped;
            seed_d   = seed_next;
            cnt_d    = '0;
            state_d  = StFill;
          end else if (loaded_q) begin
            zero_d  = 1'b0;
            state_d = StRdCur;
          end else begin
            zero_d  = 1'b1;
            state_d = StEmit;
          end
        end
      end
      StFill: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = SW'(-noise_mag);
        if (fill_last) begin
          pos_d    = '0;
          loaded_d = 1'b1;
          state_d  = StIdle;
        end else begin
          seed_d = seed_next;
          cnt_d  = AW'(cnt_q + AW'(1));
        end
      end
      StRdCur: begin
        ram_raddr = pos_q;
        state_d   = StRdNxt;
      end
      StRdNxt: begin
        ram_raddr = nxt_pos;
        state_d   = StSum;
      end
      StSum: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          sample_d    = zero_q ? '0 : cur_q;
          if (!zero_q) begin
            ram_we = 1'b1;
            pos_d  = nxt_pos;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      period_q    <= ksp_pkg::PeriodMin;
      seed_q      <= ksp_pkg::SeedReset;
      loaded_q    <= 1'b0;
      gain_q      <= ksp_pkg::GainReset;
      cnt_q       <= '0;
      amp_q       <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      period_q    <= period_d;
      seed_q      <= seed_d;
      loaded_q    <= loaded_d;
      cnt_q       <= cnt_d;
      amp_q       <= amp_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
      sample_q    <= sample_d;
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
    end
  end

  // Tap capture: the current entry, read in StRdCur, is taken into cur_q in StRdNxt;
  // the next entry, read in StRdNxt, arrives in StSum and goes straight into the sum.
  always_ff @(posedge clk_i) begin
    if (state_q == StRdNxt) begin
      cur_q <= ram_rdata;
    end
    if (state_q == StSum) begin
      sum_neg_q <= tap_sum[SW];
      sum_mag_q <= tap_sum[SW] ? (SW+1)'(-tap_sum) : (SW+1)'(tap_sum);
    end
  end

  ksp_ram #(
    .Width (SW),
    .Depth (ksp_pkg::MaxPeriod)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/ksp_checker.sv
// ----------------------------------------------------------------------------
// ksp_checker: port-level checks of the plucked string voice
// Watches the command and sample channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ksp_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              cmd_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic signed [ksp_pkg::SampleWidth-1:0] sample_o
);

  // A stalled sample beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled sample beat changed");

  // The voice is busy in the cycle after every command beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("voice ready right after a command beat");

  // No sample rises straight after a pluck beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == ksp_pkg::CmdPluck) |=> !$rose(out_valid_o))
    else $error("sample appeared after a pluck");

  // A new sample is only produced as a tick finishes, freeing the voice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("sample appeared while the voice was still busy");

endmodule

bind karplus_strong_pluck_voice ksp_checker u_ksp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sample_o    (sample_o)
);

`default_nettype wire
